### hdl/pifmt_pkg.sv
// Shared types, codes and a character helper for the printf integer formatter.
package pifmt_pkg;

   localparam int MAX_FIELD   = 60;
   localparam int DIGIT_SLOTS = 22;

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic [2:0] CONV_CHAR   = 3'd0;
   localparam logic [2:0] CONV_DEC    = 3'd1;
   localparam logic [2:0] CONV_OCT    = 3'd2;
   localparam logic [2:0] CONV_HEX_LO = 3'd3;
   localparam logic [2:0] CONV_HEX_UP = 3'd4;
   // lowest of the unsupported conversion codes; every code above it is unsupported too
   localparam logic [2:0] CONV_UNSUP  = 3'd5;

   localparam logic [7:0] ASCII_BLANK = 8'h20;
   localparam logic [7:0] ASCII_PLUS  = 8'h2B;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_X_UP  = 8'h58;
   localparam logic [7:0] ASCII_X_LO  = 8'h78;
   localparam logic [7:0] ASCII_A_UP  = 8'h41;
   localparam logic [7:0] ASCII_A_LO  = 8'h61;
   localparam logic [7:0] ASCII_NUL   = 8'h00;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SPLIT,
      ST_DABBLE,
      ST_SCAN,
      ST_PLAN,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef enum logic [2:0] {
      SEG_NONE,
      SEG_LEAD,
      SEG_PREFIX,
      SEG_ZEROS,
      SEG_OCTZ,
      SEG_CHAR,
      SEG_DIGIT,
      SEG_TAIL
   } seg_type;

   typedef struct packed {
      logic    load;
      logic    split;
      logic    dabble;
      logic    scan;
      logic    plan;
      logic    emit;
      seg_type seg;
      logic    err_emit;
   } cmd_type;

   typedef struct packed {
      logic is_err;
      logic is_char;
      logic is_dec;
      logic dabble_last;
      logic scan_end;
      logic out_free;
      logic rem_zero;
      logic lead_nz;
      logic pre_nz;
      logic zeros_nz;
      logic octz_nz;
      logic char_nz;
      logic digit_nz;
      logic tail_nz;
   } stat_type;

   // Map one digit to its ASCII glyph, upper or lower case for hex letters.
   function automatic logic [7:0] glyph(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? ASCII_A_UP : ASCII_A_LO;
      if (d < 4'd10) begin
         glyph = ASCII_ZERO + {4'b0000, d};
      end else begin
         glyph = base + {4'b0000, d} - 8'd10;
      end
   endfunction

endpackage

### hdl/printf_integer_formatter_core.sv
// Top level of the printf integer formatter: controller and datapath joined.
//
// Formats one 64-bit magnitude with a sign flag under a printf integer
// conversion (character, decimal, octal, lower or upper hex) and returns the
// text one ASCII character per response, tlast on the final one. A request
// is taken only when the block is idle; it then decodes the request,
// converts the magnitude to digits (shift-and-add-3 binary to decimal
// conversion for decimal, a single digit split for octal and hex), scans
// the digit store down to the leading significant digit, lays out the
// field and emits one character per cycle (up to 63) while the output
// register is free, then returns to idle. A character conversion goes
// from decode straight to the layout. Emission stalls while the output
// register holds a character not yet taken. Width and precision above 60
// are clamped to 60. An unsupported conversion code returns a single
// response with character 0 and tuser set; a request that formats to no
// text at all (zero value, precision 0, no width, no sign or prefix)
// returns no response.
module printf_integer_formatter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // magnitude[63:0], is_negative[64], left_justify[65], force_plus[66],
   // space_sign[67], alternate_form[68], zero_fill[69], field_width[75:70],
   // has_precision[76], min_digits[82:77], zeros above
   input  logic [pifmt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // conversion[2:0]
   input  logic [pifmt_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // character[7:0]
   output logic [pifmt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status[0]
   output logic [0:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);
   import pifmt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequence the phases of one request
   pifmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // hold the request, convert, lay out and emit characters
   pifmt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

### hdl/pifmt_ctrl.sv
// Sequencing state machine of the printf integer formatter.
module pifmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pifmt_pkg::stat_type stat,
   output pifmt_pkg::cmd_type  cmd
);
   import pifmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            priority if (stat.is_err) state_in = ST_ERROR;
            else if (stat.is_char)    state_in = ST_PLAN;
            else if (stat.is_dec)     state_in = ST_DABBLE;
            else                      state_in = ST_SPLIT;
         end
         ST_SPLIT:  state_in = ST_SCAN;
         ST_DABBLE: begin
            if (stat.dabble_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_end) state_in = ST_PLAN;
         end
         ST_PLAN:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.rem_zero) state_in = ST_IDLE;
         end
         ST_ERROR: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cmd          = '0;
      cmd.seg      = SEG_NONE;
      cmd.load     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.split    = (state_ff == ST_SPLIT);
      cmd.dabble   = (state_ff == ST_DABBLE);
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.plan     = (state_ff == ST_PLAN);
      cmd.err_emit = (state_ff == ST_ERROR) && stat.out_free;
      if ((state_ff == ST_EMIT) && !stat.rem_zero && stat.out_free) begin
         cmd.emit = 1'b1;
         // pick the first segment that still has characters
         priority if (stat.lead_nz) cmd.seg = SEG_LEAD;
         else if (stat.pre_nz)      cmd.seg = SEG_PREFIX;
         else if (stat.zeros_nz)    cmd.seg = SEG_ZEROS;
         else if (stat.octz_nz)     cmd.seg = SEG_OCTZ;
         else if (stat.char_nz)     cmd.seg = SEG_CHAR;
         else if (stat.digit_nz)    cmd.seg = SEG_DIGIT;
         else if (stat.tail_nz)     cmd.seg = SEG_TAIL;
         else                       cmd.seg = SEG_NONE;
      end
   end

endmodule

### hdl/pifmt_dpath.sv
// Datapath of the printf integer formatter: digit store, layout counters, output register.
module pifmt_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [pifmt_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [pifmt_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pifmt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,
   output logic [0:0]                            rsp_tuser,
   input  pifmt_pkg::cmd_type                    cmd,
   output pifmt_pkg::stat_type                   stat
);
   import pifmt_pkg::*;

   localparam int PTR_W = $clog2(DIGIT_SLOTS);
   localparam int ND_W  = $clog2(DIGIT_SLOTS + 1);

   // request fields
   logic [63:0] mag_ff;
   logic        neg_ff, left_ff, plus_ff, space_ff, alt_ff, zfill_ff;
   logic [2:0]  conv_ff;
   logic [5:0]  width_ff, prec_ff;

   // digit store and conversion
   logic [DIGIT_SLOTS-1:0][3:0] digits_ff, digits_in;
   logic [5:0]                  bit_cnt_ff;
   logic [PTR_W-1:0]            ptr_ff, ptr_in;
   logic [ND_W-1:0]             nd_ff, nd_in;

   // layout counters
   logic [5:0]  lead_ff, lead_in, tail_ff, tail_in;
   logic [23:0] pre_ff, pre_in;
   logic [1:0]  pre_cnt_ff, pre_cnt_in;
   logic [6:0]  zeros_ff, zeros_in, rem_ff, rem_in;
   logic        octz_ff, octz_in, char_ff, char_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in, rsp_status_ff, rsp_status_in;

   logic [5:0] width_raw, prec_raw;
   logic       is_hex, is_oct;
   logic [7:0] char_byte;
   logic [3:0] cur_digit;

   assign width_raw = req_tdata[75:70];
   assign prec_raw  = req_tdata[82:77];
   assign is_hex    = (conv_ff == CONV_HEX_LO) || (conv_ff == CONV_HEX_UP);
   assign is_oct    = (conv_ff == CONV_OCT);
   assign char_byte = neg_ff ? (8'd0 - mag_ff[7:0]) : mag_ff[7:0];
   assign cur_digit = digits_ff[ptr_ff];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff   <= req_tdata[63:0];
         neg_ff   <= req_tdata[64];
         left_ff  <= req_tdata[65];
         plus_ff  <= req_tdata[66];
         space_ff <= req_tdata[67];
         alt_ff   <= req_tdata[68];
         zfill_ff <= req_tdata[69];
         conv_ff  <= req_tuser;
         width_ff <= (width_raw > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : width_raw;
         if (!req_tdata[76]) begin
            prec_ff <= 6'd1;
         end else begin
            prec_ff <= (prec_raw > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : prec_raw;
         end
      end
   end

   // conversion: one binary digit per cycle for decimal, all digits at once for powers of two
   logic [DIGIT_SLOTS-1:0][3:0] corr;
   logic [4*DIGIT_SLOTS-1:0]    ext;
   always_comb begin
      ext = {{(4*DIGIT_SLOTS-64){1'b0}}, mag_ff};
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         corr[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      digits_in = digits_ff;
      if (cmd.load) begin
         digits_in = '0;
      end else if (cmd.dabble) begin
         // correct each decade, then shift the next magnitude bit in at the bottom
         digits_in = {corr[DIGIT_SLOTS-1][2:0], corr[DIGIT_SLOTS-2:0], mag_ff[~bit_cnt_ff]};
      end else if (cmd.split) begin
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            if (is_hex) begin
               digits_in[i] = ext[4*i +: 4];
            end else begin
               digits_in[i] = {1'b0, ext[3*i +: 3]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      if (reset || cmd.load) begin
         bit_cnt_ff <= '0;
      end else if (cmd.dabble) begin
         bit_cnt_ff <= bit_cnt_ff + 6'd1;
      end
   end

   // layout plan
   logic       sign_en, x_en;
   logic [7:0] sign_ch, x_ch;
   logic [1:0] plen;
   logic [5:0] vlen, zeros, blanks, pad;
   logic [6:0] used;
   logic       zf;
   always_comb begin
      sign_en = neg_ff | plus_ff | space_ff;
      sign_ch = neg_ff ? ASCII_MINUS : (plus_ff ? ASCII_PLUS : ASCII_BLANK);
      x_en    = alt_ff && (mag_ff != 64'd0) && is_hex;
      x_ch    = (conv_ff == CONV_HEX_UP) ? ASCII_X_UP : ASCII_X_LO;
      plen    = {1'b0, sign_en} + (x_en ? 2'd2 : 2'd0);
      vlen    = 6'(nd_ff) + {5'd0, (alt_ff && is_oct)};
      zeros   = (prec_ff > vlen) ? prec_ff - vlen : 6'd0;
      used    = {1'b0, zeros} + {1'b0, vlen} + {5'd0, plen};
      blanks  = ({1'b0, width_ff} > used) ? 6'({1'b0, width_ff} - used) : 6'd0;
      zf      = zfill_ff && !left_ff;
      pad     = (width_ff != 6'd0) ? width_ff - 6'd1 : 6'd0;

      lead_in    = lead_ff;
      tail_in    = tail_ff;
      pre_in     = pre_ff;
      pre_cnt_in = pre_cnt_ff;
      zeros_in   = zeros_ff;
      octz_in    = octz_ff;
      char_in    = char_ff;
      rem_in     = rem_ff;
      ptr_in     = ptr_ff;
      nd_in      = nd_ff;

      if (cmd.load) begin
         ptr_in = PTR_W'(DIGIT_SLOTS - 1);
         nd_in  = '0;
      end else if (cmd.scan) begin
         // walk down from the top slot to the leading significant digit
         if (cur_digit != 4'd0) begin
            nd_in = ND_W'(ptr_ff) + ND_W'(1);
         end else if (ptr_ff != '0) begin
            ptr_in = ptr_ff - PTR_W'(1);
         end
      end else if (cmd.plan) begin
         if (conv_ff == CONV_CHAR) begin
            lead_in    = left_ff ? 6'd0 : pad;
            tail_in    = left_ff ? pad : 6'd0;
            pre_cnt_in = 2'd0;
            zeros_in   = 7'd0;
            octz_in    = 1'b0;
            char_in    = 1'b1;
            rem_in     = {1'b0, pad} + 7'd1;
         end else begin
            lead_in    = (!left_ff && !zfill_ff) ? blanks : 6'd0;
            tail_in    = left_ff ? blanks : 6'd0;
            pre_in     = sign_en ? {sign_ch, ASCII_ZERO, x_ch} : {ASCII_ZERO, x_ch, ASCII_NUL};
            pre_cnt_in = plen;
            zeros_in   = {1'b0, zeros} + (zf ? {1'b0, blanks} : 7'd0);
            octz_in    = alt_ff && is_oct;
            char_in    = 1'b0;
            rem_in     = {1'b0, lead_in} + {5'd0, plen} + zeros_in + {6'd0, octz_in}
                       + 7'(nd_ff) + {1'b0, tail_in};
         end
      end else if (cmd.emit) begin
         rem_in = rem_ff - 7'd1;
         unique case (cmd.seg)
            SEG_LEAD:   lead_in = lead_ff - 6'd1;
            SEG_PREFIX: begin
               pre_in     = {pre_ff[15:0], ASCII_NUL};
               pre_cnt_in = pre_cnt_ff - 2'd1;
            end
            SEG_ZEROS:  zeros_in = zeros_ff - 7'd1;
            SEG_OCTZ:   octz_in  = 1'b0;
            SEG_CHAR:   char_in  = 1'b0;
            SEG_DIGIT: begin
               ptr_in = ptr_ff - PTR_W'(1);
               nd_in  = nd_ff - ND_W'(1);
            end
            SEG_TAIL:   tail_in = tail_ff - 6'd1;
            default:    rem_in  = rem_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lead_ff    <= lead_in;
      tail_ff    <= tail_in;
      pre_ff     <= pre_in;
      pre_cnt_ff <= pre_cnt_in;
      zeros_ff   <= zeros_in;
      octz_ff    <= octz_in;
      char_ff    <= char_in;
      ptr_ff     <= ptr_in;
      nd_ff      <= nd_in;
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   // output register: load a character when the slot is free, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.err_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_char_in   = ASCII_NUL;
         rsp_last_in   = 1'b1;
         rsp_status_in = STATUS_ERR;
      end else if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_last_in   = (rem_ff == 7'd1);
         rsp_status_in = STATUS_OK;
         unique case (cmd.seg)
            SEG_PREFIX: rsp_char_in = pre_ff[23:16];
            SEG_ZEROS,
            SEG_OCTZ:   rsp_char_in = ASCII_ZERO;
            SEG_CHAR:   rsp_char_in = char_byte;
            SEG_DIGIT:  rsp_char_in = glyph(cur_digit, conv_ff == CONV_HEX_UP);
            default:    rsp_char_in = ASCII_BLANK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_char_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_status_ff;

   always_comb begin
      stat.is_err      = (conv_ff > CONV_HEX_UP);
      stat.is_char     = (conv_ff == CONV_CHAR);
      stat.is_dec      = (conv_ff == CONV_DEC);
      stat.dabble_last = &bit_cnt_ff;
      stat.scan_end    = (cur_digit != 4'd0) || (ptr_ff == '0);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
      stat.rem_zero    = (rem_ff == 7'd0);
      stat.lead_nz     = (lead_ff != 6'd0);
      stat.pre_nz      = (pre_cnt_ff != 2'd0);
      stat.zeros_nz    = (zeros_ff != 7'd0);
      stat.octz_nz     = octz_ff;
      stat.char_nz     = char_ff;
      stat.digit_nz    = (nd_ff != '0);
      stat.tail_nz     = (tail_ff != 6'd0);
   end

endmodule

### tb/sv/pifmt_text_checker.sv
// Checker for the printf integer formatter: predicts the text of each request and compares it.
module pifmt_text_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pifmt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pifmt_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [pifmt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [0:0]                       rsp_tuser,
   input  logic                             rsp_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output int                               fail_count,
   output int                               pending_chars,
   output int                               chars_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import pifmt_pkg::*;

   // Request payload, lowest field last in the list.
   typedef struct packed {
      logic [4:0]  spare;
      logic [5:0]  min_digits;
      logic        has_precision;
      logic [5:0]  field_width;
      logic        zero_fill;
      logic        alternate_form;
      logic        space_sign;
      logic        force_plus;
      logic        left_justify;
      logic        is_negative;
      logic [63:0] magnitude;
   } fmt_request_type;

   typedef struct {
      logic [7:0] character;
      logic       last;
      logic       status;
   } text_char_type;

   text_char_type expected_text[$];
   int            mismatches;
   int            checked;

   // Build the characters one request formats to and queue them.
   function automatic void predict_text(input fmt_request_type r, input logic [2:0] conv);
      logic [7:0]    text[$];
      logic [7:0]    lead[$];
      logic [3:0]    digits[$];
      logic [63:0]   rest;
      logic [63:0]   radix;
      string         glyphs;
      int            width;
      int            prec;
      int            vlen;
      int            zeros;
      int            blanks;
      bit            fill;
      bit            oct_lead;
      text_char_type entry;

      width = (r.field_width > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
      prec  = (r.min_digits > MAX_FIELD) ? MAX_FIELD : int'(r.min_digits);
      if (!r.has_precision) prec = 1;

      if (conv > CONV_HEX_UP) begin
         entry.character = ASCII_NUL;
         entry.last      = 1'b1;
         entry.status    = STATUS_ERR;
         expected_text.push_back(entry);
         return;
      end

      if (conv == CONV_CHAR) begin
         rest = r.is_negative ? (64'd0 - r.magnitude) : r.magnitude;
         if (r.left_justify) text.push_back(rest[7:0]);
         repeat ((width > 0) ? width - 1 : 0) text.push_back(ASCII_BLANK);
         if (!r.left_justify) text.push_back(rest[7:0]);
      end else begin
         radix  = (conv == CONV_DEC) ? 64'd10 : ((conv == CONV_OCT) ? 64'd8 : 64'd16);
         glyphs = (conv == CONV_HEX_UP) ? "0123456789ABCDEF" : "0123456789abcdef";
         if (r.is_negative) lead.push_back(ASCII_MINUS);
         else if (r.force_plus) lead.push_back(ASCII_PLUS);
         else if (r.space_sign) lead.push_back(ASCII_BLANK);
         if (r.alternate_form && r.magnitude != 64'd0
             && (conv == CONV_HEX_LO || conv == CONV_HEX_UP)) begin
            lead.push_back(ASCII_ZERO);
            lead.push_back((conv == CONV_HEX_UP) ? ASCII_X_UP : ASCII_X_LO);
         end
         // least significant digit first
         rest = r.magnitude;
         while (rest != 64'd0) begin
            digits.push_back(4'(rest % radix));
            rest = rest / radix;
         end
         oct_lead = r.alternate_form && conv == CONV_OCT;
         vlen     = digits.size() + int'(oct_lead);
         zeros    = prec - vlen;
         if (zeros < 0) zeros = 0;
         blanks   = width - zeros - vlen - lead.size();
         if (blanks < 0) blanks = 0;
         fill     = r.zero_fill && !r.left_justify;

         if (!r.left_justify && !fill) repeat (blanks) text.push_back(ASCII_BLANK);
         foreach (lead[i]) text.push_back(lead[i]);
         repeat (zeros + (fill ? blanks : 0)) text.push_back(ASCII_ZERO);
         if (oct_lead) text.push_back(ASCII_ZERO);
         for (int i = digits.size() - 1; i >= 0; i--) text.push_back(glyphs[digits[i]]);
         if (r.left_justify) repeat (blanks) text.push_back(ASCII_BLANK);
      end

      foreach (text[i]) begin
         entry.character = text[i];
         entry.last      = (i == text.size() - 1);
         entry.status    = STATUS_OK;
         expected_text.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         if (req_tvalid && req_tready) predict_text(fmt_request_type'(req_tdata), req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_text.size() == 0) begin
               $error("unexpected character %h (last %b, status %b)",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.character) begin
                  $error("character: expected %h, got %h", want.character, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_tuser[0]);
                  mismatches++;
               end
            end
         end
      end
      // publish after the edge so readers at this edge see one consistent value
      fail_count    <= mismatches;
      pending_chars <= expected_text.size();
      chars_checked <= checked;
   end

endmodule

### tb/sv/printf_integer_formatter_core_test.sv
// Test top for the printf integer formatter: stimulus, backpressure and the verdict.
module printf_integer_formatter_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pifmt_pkg::*;

   localparam int RANDOM_REQUESTS = 295;
   localparam int CALM_FROM       = 265;   // random request index where idling stops
   localparam int LONG_HOLD       = 600;   // cycles the sink refuses characters once
   localparam int DRAIN_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles before giving up

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;

   int fail_count;
   int pending_chars;
   int chars_checked;
   int idle_cycles;
   int requests_sent;
   int per_conv[8];
   bit calm;            // no idling on either side once set
   bit long_hold_due;   // ask the sink for its one long stall

   printf_integer_formatter_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   pifmt_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .fail_count    (fail_count),
      .pending_chars (pending_chars),
      .chars_checked (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pack the request fields into tdata, magnitude in the lowest bits.
   function automatic logic [REQ_DATA_W-1:0] pack_request(
      input logic [63:0] mag, input logic neg, input logic left, input logic plus,
      input logic space, input logic alt, input logic zfill, input logic [5:0] width,
      input logic hasp, input logic [5:0] prec);
      pack_request = {5'd0, prec, hasp, width, zfill, alt, space, plus, left, neg, mag};
   endfunction

   // One random flag bit.
   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Offer one request, perhaps after an idle burst, and hold it until taken.
   task automatic offer_request(input logic [REQ_DATA_W-1:0] data, input logic [2:0] conv);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= data;
      req_tuser  <= conv;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      per_conv[conv]++;
   endtask

   task automatic offer_fmt(input logic [63:0] mag, input logic neg, input logic [2:0] conv,
      input logic left, input logic plus, input logic space, input logic alt,
      input logic zfill, input logic [5:0] width, input logic hasp, input logic [5:0] prec);
      offer_request(pack_request(mag, neg, left, plus, space, alt, zfill, width, hasp, prec),
                    conv);
   endtask

   // Hold the sender until every predicted character has been taken.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
   endtask

   // Random request: mostly supported conversions, mixed magnitudes, narrow fields.
   task automatic offer_random();
      logic [63:0] mag;
      logic [2:0]  conv;
      logic [5:0]  width;
      logic [5:0]  prec;
      case ($urandom_range(0, 6))
         0:       mag = 64'd0;
         1:       mag = 64'($urandom_range(0, 999));
         2:       mag = {$urandom, $urandom};
         3:       mag = 64'd1 << $urandom_range(0, 63);
         4:       mag = ~64'd0 >> $urandom_range(0, 63);
         5:       mag = ~64'd0;
         default: mag = 64'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 19) < 2) conv = CONV_UNSUP + 3'($urandom_range(0, 2));
      else conv = 3'($urandom_range(32'(CONV_CHAR), 32'(CONV_HEX_UP)));
      width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 12));
      prec  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 6));
      offer_fmt(mag, coin(), conv, coin(), coin(), coin(), coin(), coin(), width,
                coin(), prec);
   endtask

   // Response sink: random stalls, one long hold-off on request, none when calm.
   initial begin : rsp_sink
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a request or a character.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CONV_CHAR;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: unsupported codes, including every bit of every field set
      offer_fmt(64'd0, 1'b0, CONV_UNSUP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(~64'd0, 1'b1, CONV_UNSUP + 3'd2, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 6'd63,
                1'b1, 6'd63);
      offer_fmt(64'd99, 1'b0, CONV_UNSUP + 3'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd4,
                1'b0, 6'd0);
      // character conversion: right and left padding, negation, flags ignored, clamp
      offer_fmt(64'd65, 1'b0, CONV_CHAR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd5, 1'b0, 6'd0);
      offer_fmt(64'd122, 1'b0, CONV_CHAR, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd3, 1'b0, 6'd0);
      offer_fmt(64'd1, 1'b1, CONV_CHAR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'h1234_5678_9ABC_DE41, 1'b0, CONV_CHAR, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
                6'd63, 1'b1, 6'd63);
      // decimal: full range, zero value with and without digits, negative zero, signs
      offer_fmt(~64'd0, 1'b1, CONV_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'd0, 1'b0, CONV_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b1, 6'd0);
      offer_fmt(64'd0, 1'b0, CONV_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'd0, 1'b1, CONV_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'd42, 1'b0, CONV_DEC, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'd42, 1'b0, CONV_DEC, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'd42, 1'b0, CONV_DEC, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);
      // zero fill with precision, left justify overriding it, clamp, zero as blanks
      offer_fmt(64'd123, 1'b0, CONV_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd10, 1'b1, 6'd5);
      offer_fmt(64'd123, 1'b0, CONV_DEC, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 6'd10, 1'b0, 6'd0);
      offer_fmt(64'd7, 1'b0, CONV_DEC, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd63, 1'b1, 6'd63);
      offer_fmt(64'd0, 1'b0, CONV_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd3, 1'b1, 6'd0);
      // hex: zero value drops the prefix, padded and signed prefixes, both cases
      offer_fmt(64'd0, 1'b0, CONV_HEX_LO, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0, 1'b0, 6'd0);
      offer_fmt(64'hDEAD_BEEF, 1'b0, CONV_HEX_LO, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 6'd16,
                1'b0, 6'd0);
      offer_fmt(64'hDEAD_BEEF_CAFE_F00D, 1'b0, CONV_HEX_UP, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                6'd0, 1'b0, 6'd0);
      offer_fmt(~64'd0, 1'b1, CONV_HEX_UP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd30, 1'b0, 6'd0);
      // octal: alternate leading zero survives precision zero, widest value
      offer_fmt(64'd0, 1'b0, CONV_OCT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0, 1'b1, 6'd0);
      offer_fmt(~64'd0, 1'b0, CONV_OCT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd40, 1'b1, 6'd30);
      offer_fmt(64'd8, 1'b0, CONV_OCT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == CALM_FROM) calm = 1'b1;
         if (n == 40 || n == 180) wait_for_drain();
         // the sink stalls long while requests keep coming, so the block backs up
         if (n == 100) long_hold_due = 1'b1;
         offer_random();
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d requests: char %0d, dec %0d, oct %0d, hex %0d/%0d, bad code %0d",
               requests_sent, per_conv[CONV_CHAR], per_conv[CONV_DEC], per_conv[CONV_OCT],
               per_conv[CONV_HEX_LO], per_conv[CONV_HEX_UP],
               per_conv[CONV_UNSUP] + per_conv[CONV_UNSUP + 3'd1]
               + per_conv[CONV_UNSUP + 3'd2]);
      $display("Checked %0d characters under random stalls and one long sink hold-off",
               chars_checked);
      if (pending_chars != 0) $error("%0d characters never arrived", pending_chars);
      if (fail_count == 0 && pending_chars == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
